[rtl/core/qti_pkg.sv]
// Shared types, widths and the arithmetic step program of the quadratic table interpolator.
// Used by the controller, the datapath and the top level; depends on nothing.
package qti_pkg;

   localparam int DEFAULT_DEPTH = 256;
   localparam int LEN_W         = 9;
   localparam int IDX_W         = 8;
   localparam int VAL_W         = 32;
   localparam int OPND_W        = 33;
   localparam int BIT_W         = $clog2(OPND_W);
   localparam int WIDE_W        = 136;
   localparam int DIV_CNT_W     = $clog2(WIDE_W);
   localparam int NUM_STEPS     = 19;
   localparam int STEP_W        = $clog2(NUM_STEPS);

   // Request mode codes.
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SRCH_RD, ST_SRCH_CMP, ST_BASE, ST_TRI_RD, ST_TRI_CAP, ST_DIFF,
      ST_CHK, ST_STEP, ST_MUL, ST_MUL_DONE, ST_DIV_INIT, ST_DIV, ST_ROUND, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_LOAD, OP_START, OP_SRCH_RD, OP_SRCH_UPD, OP_BASE, OP_TRI_RD,
      OP_TRI_CAP, OP_DIFF, OP_SETP, OP_SUM_SET, OP_SUM_SUB, OP_SUM_ADD, OP_DEN_SET,
      OP_MUL_STEP, OP_MUL_DONE, OP_DIV_INIT, OP_DIV_STEP, OP_ROUND, OP_FINISH
   } op_type;

   typedef enum logic [3:0] {
      SRC_Y0, SRC_Y1, SRC_Y2, SRC_QX0, SRC_QX1, SRC_QX2, SRC_D01, SRC_D02, SRC_D12
   } src_type;

   typedef enum logic [2:0] {
      K_SETP, K_MUL, K_SUM_SET, K_SUM_SUB, K_SUM_ADD, K_DEN_SET
   } kind_type;

   typedef struct packed {
      kind_type kind;
      src_type  src;
   } step_type;

   typedef struct packed {
      op_type           op;
      src_type          src;
      logic [1:0]       slot;
      logic [BIT_W-1:0] bit_idx;
   } cmd_type;

   typedef struct packed {
      logic more;
      logic degen;
      logic out_free;
   } status_type;

   // Numerator terms y0*(q-x1)*(q-x2)*d12 - y1*(q-x0)*(q-x2)*d02 + y2*(q-x0)*(q-x1)*d01,
   // then the denominator d01*d02*d12.
   function automatic step_type prog_step(input logic [STEP_W-1:0] idx);
      step_type s;
      s = '{kind: K_SETP, src: SRC_Y0};
      case (idx)
         5'd0:    s = '{kind: K_SETP,    src: SRC_Y0};
         5'd1:    s = '{kind: K_MUL,     src: SRC_QX1};
         5'd2:    s = '{kind: K_MUL,     src: SRC_QX2};
         5'd3:    s = '{kind: K_MUL,     src: SRC_D12};
         5'd4:    s = '{kind: K_SUM_SET, src: SRC_Y0};
         5'd5:    s = '{kind: K_SETP,    src: SRC_Y1};
         5'd6:    s = '{kind: K_MUL,     src: SRC_QX0};
         5'd7:    s = '{kind: K_MUL,     src: SRC_QX2};
         5'd8:    s = '{kind: K_MUL,     src: SRC_D02};
         5'd9:    s = '{kind: K_SUM_SUB, src: SRC_Y0};
         5'd10:   s = '{kind: K_SETP,    src: SRC_Y2};
         5'd11:   s = '{kind: K_MUL,     src: SRC_QX0};
         5'd12:   s = '{kind: K_MUL,     src: SRC_QX1};
         5'd13:   s = '{kind: K_MUL,     src: SRC_D01};
         5'd14:   s = '{kind: K_SUM_ADD, src: SRC_Y0};
         5'd15:   s = '{kind: K_SETP,    src: SRC_D01};
         5'd16:   s = '{kind: K_MUL,     src: SRC_D02};
         5'd17:   s = '{kind: K_MUL,     src: SRC_D12};
         5'd18:   s = '{kind: K_DEN_SET, src: SRC_Y0};
         default: s = '{kind: K_SETP,    src: SRC_Y0};
      endcase
      return s;
   endfunction

endpackage

[rtl/core/quadratic_table_interpolator.sv]
//  channel | ports                                   | direction | beat
//  req     | req_valid/ready, mode, index, x, y, qx  | in        | one load or one query
//  rsp     | rsp_valid/ready, value, saturated, degen| out       | one result per query
//  csr     | csr_wr_en, csr_wr_data                  | in        | table length write
// A load beat is written to the table as it is accepted, and the block stays ready. A query
// runs a search with one table read and compare per halving, then eleven serial multiplies
// and a restoring divide, which dominate. Coincident x points skip the arithmetic.
// One beat is in work at a time; a
// finished result waits in the output register while the next beat is accepted. Synchronous
// reset sets the table length to three; table contents are undefined until loaded.
module quadratic_table_interpolator import qti_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [LEN_W-1:0]        csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_mode,
   input  logic [IDX_W-1:0]        req_entry_index,
   input  logic signed [VAL_W-1:0] req_entry_x,
   input  logic signed [VAL_W-1:0] req_entry_y,
   input  logic signed [VAL_W-1:0] req_query_x,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_value,
   output logic                    rsp_saturated,
   output logic                    rsp_degenerate
);

   cmd_type    cmd;
   status_type status;

   qti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   qti_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_entry_index (req_entry_index),
      .req_entry_x     (req_entry_x),
      .req_entry_y     (req_entry_y),
      .req_query_x     (req_query_x),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value),
      .rsp_saturated   (rsp_saturated),
      .rsp_degenerate  (rsp_degenerate)
   );

endmodule

[rtl/core/qti_ctrl.sv]
// Sequencer of the quadratic table interpolator: search, fetch, multiply, divide, respond.
// Depends on qti_pkg; drives the datapath through a command struct.
module qti_ctrl import qti_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_mode,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type            state_ff, state_in;
   logic [1:0]           k_ff, k_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [DIV_CNT_W-1:0] div_ff, div_in;
   step_type             cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         step_ff  <= '0;
         bit_ff   <= '0;
         div_ff   <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         step_ff  <= step_in;
         bit_ff   <= bit_in;
         div_ff   <= div_in;
      end
   end

   assign cur = prog_step(step_ff);

   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      step_in     = step_ff;
      bit_in      = bit_ff;
      div_in      = div_ff;
      req_ready   = 1'b0;
      cmd.op      = OP_NOP;
      cmd.src     = cur.src;
      cmd.slot    = k_ff;
      cmd.bit_idx = bit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == MODE_QUERY) begin
                  cmd.op   = OP_START;
                  state_in = ST_SRCH_RD;
               end else begin
                  cmd.op = OP_LOAD;
               end
            end
         end
         ST_SRCH_RD: begin
            if (status.more) begin
               cmd.op   = OP_SRCH_RD;
               state_in = ST_SRCH_CMP;
            end else begin
               state_in = ST_BASE;
            end
         end
         ST_SRCH_CMP: begin
            cmd.op   = OP_SRCH_UPD;
            state_in = ST_SRCH_RD;
         end
         ST_BASE: begin
            cmd.op   = OP_BASE;
            k_in     = '0;
            state_in = ST_TRI_RD;
         end
         ST_TRI_RD: begin
            cmd.op   = OP_TRI_RD;
            state_in = ST_TRI_CAP;
         end
         ST_TRI_CAP: begin
            cmd.op = OP_TRI_CAP;
            if (k_ff == 2'd2) begin
               state_in = ST_DIFF;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_TRI_RD;
            end
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            step_in  = '0;
            state_in = status.degen ? ST_DONE : ST_STEP;
         end
         ST_STEP: begin
            unique case (cur.kind)
               K_MUL: begin
                  bit_in   = BIT_W'(OPND_W - 1);
                  state_in = ST_MUL;
               end
               K_SETP:    cmd.op = OP_SETP;
               K_SUM_SET: cmd.op = OP_SUM_SET;
               K_SUM_SUB: cmd.op = OP_SUM_SUB;
               K_SUM_ADD: cmd.op = OP_SUM_ADD;
               K_DEN_SET: cmd.op = OP_DEN_SET;
               default:   cmd.op = OP_NOP;
            endcase
            if (cur.kind != K_MUL) begin
               if (step_ff == STEP_W'(NUM_STEPS - 1)) begin
                  state_in = ST_DIV_INIT;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         ST_MUL: begin
            cmd.op = OP_MUL_STEP;
            if (bit_ff == '0) begin
               state_in = ST_MUL_DONE;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         ST_MUL_DONE: begin
            cmd.op   = OP_MUL_DONE;
            step_in  = step_ff + 1'b1;
            state_in = ST_STEP;
         end
         ST_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            div_in   = DIV_CNT_W'(WIDE_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (div_ff == '0) begin
               state_in = ST_ROUND;
            end else begin
               div_in = div_ff - 1'b1;
            end
         end
         ST_ROUND: begin
            cmd.op   = OP_ROUND;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.op   = OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[rtl/core/qti_datapath.sv]
// Table memories, search registers, serial multiplier, restoring divider and response register.
// Depends on qti_pkg; acts only on commands from qti_ctrl.
module qti_datapath import qti_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic                    csr_wr_en,
   input  logic [LEN_W-1:0]        csr_wr_data,
   input  logic [IDX_W-1:0]        req_entry_index,
   input  logic signed [VAL_W-1:0] req_entry_x,
   input  logic signed [VAL_W-1:0] req_entry_y,
   input  logic signed [VAL_W-1:0] req_query_x,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_value,
   output logic                    rsp_saturated,
   output logic                    rsp_degenerate
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [VAL_W-1:0] x_mem [TABLE_DEPTH];
   logic [VAL_W-1:0] y_mem [TABLE_DEPTH];
   logic signed [VAL_W-1:0] rd_x_ff, rd_y_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;

   logic [LEN_W-1:0] len_ff;
   logic [CW-1:0]    n_val, lo_ff, hi_ff, mid, base_ff, base_in, tri_idx;
   logic signed [VAL_W-1:0] q_ff;
   logic signed [VAL_W-1:0] tx_ff [3];
   logic signed [VAL_W-1:0] ty_ff [3];
   logic signed [OPND_W-1:0] qx0_ff, qx1_ff, qx2_ff, d01_ff, d02_ff, d12_ff;
   logic degen_ff;

   logic signed [OPND_W-1:0] opnd;
   logic signed [WIDE_W-1:0] p_ff, r_ff, s_ff, d_ff, addend, r_base;
   logic [WIDE_W-1:0] nq_ff, dm_ff;
   logic [WIDE_W:0]   rem_ff, rem_sh;
   logic              neg_ff, up;
   logic [WIDE_W+1:0] twice;

   logic              rsp_valid_ff;
   logic [VAL_W-1:0]  rsp_value_ff;
   logic              rsp_sat_ff, rsp_degen_ff;
   logic [WIDE_W-1:0] limit;
   logic              sat;

   // Effective length clamps to the range three to TABLE_DEPTH.
   always_comb begin
      if (32'(len_ff) < 3) begin
         n_val = CW'(3);
      end else if (32'(len_ff) > TABLE_DEPTH) begin
         n_val = CW'(TABLE_DEPTH);
      end else begin
         n_val = CW'(len_ff);
      end
   end

   assign mid     = CW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign tri_idx = base_ff + CW'(cmd.slot);
   assign rd_addr = (cmd.op == OP_TRI_RD) ? tri_idx[AW-1:0] : mid[AW-1:0];
   assign wr_addr = AW'(req_entry_index);
   assign wr_en   = (cmd.op == OP_LOAD) && (32'(req_entry_index) < TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_mem[wr_addr] <= req_entry_x;
         y_mem[wr_addr] <= req_entry_y;
      end
      rd_x_ff <= x_mem[rd_addr];
      rd_y_ff <= y_mem[rd_addr];
   end

   // Near the top end the triple starts two entries below the bracket, or at entry zero.
   always_comb begin
      if (lo_ff < n_val - CW'(2)) begin
         base_in = lo_ff;
      end else if (lo_ff >= CW'(2)) begin
         base_in = lo_ff - CW'(2);
      end else begin
         base_in = '0;
      end
   end

   always_comb begin
      case (cmd.src)
         SRC_Y0:  opnd = OPND_W'(ty_ff[0]);
         SRC_Y1:  opnd = OPND_W'(ty_ff[1]);
         SRC_Y2:  opnd = OPND_W'(ty_ff[2]);
         SRC_QX0: opnd = qx0_ff;
         SRC_QX1: opnd = qx1_ff;
         SRC_QX2: opnd = qx2_ff;
         SRC_D01: opnd = d01_ff;
         SRC_D02: opnd = d02_ff;
         SRC_D12: opnd = d12_ff;
         default: opnd = '0;
      endcase
   end

   // Most significant multiplier bit first; the sign bit carries negative weight.
   always_comb begin
      if (!opnd[cmd.bit_idx]) begin
         addend = '0;
      end else if (cmd.bit_idx == BIT_W'(OPND_W - 1)) begin
         addend = -p_ff;
      end else begin
         addend = p_ff;
      end
      r_base = (cmd.bit_idx == BIT_W'(OPND_W - 1)) ? '0 : (r_ff <<< 1);
   end

   assign rem_sh = {rem_ff[WIDE_W-1:0], nq_ff[WIDE_W-1]};
   assign twice  = {rem_ff, 1'b0};
   assign up     = twice >= {2'b00, dm_ff};
   assign limit  = neg_ff ? (WIDE_W'(1) << 31) : ((WIDE_W'(1) << 31) - WIDE_W'(1));
   assign sat    = nq_ff > limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(3);
      end else if (csr_wr_en) begin
         len_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_START: begin
            q_ff  <= req_query_x;
            lo_ff <= '0;
            hi_ff <= n_val - CW'(1);
         end
         OP_SRCH_UPD: begin
            if (q_ff >= rd_x_ff) begin
               lo_ff <= mid;
            end else begin
               hi_ff <= mid;
            end
         end
         OP_BASE: base_ff <= base_in;
         OP_TRI_CAP: begin
            tx_ff[cmd.slot] <= rd_x_ff;
            ty_ff[cmd.slot] <= rd_y_ff;
         end
         OP_DIFF: begin
            qx0_ff   <= OPND_W'(q_ff) - OPND_W'(tx_ff[0]);
            qx1_ff   <= OPND_W'(q_ff) - OPND_W'(tx_ff[1]);
            qx2_ff   <= OPND_W'(q_ff) - OPND_W'(tx_ff[2]);
            d01_ff   <= OPND_W'(tx_ff[0]) - OPND_W'(tx_ff[1]);
            d02_ff   <= OPND_W'(tx_ff[0]) - OPND_W'(tx_ff[2]);
            d12_ff   <= OPND_W'(tx_ff[1]) - OPND_W'(tx_ff[2]);
            degen_ff <= (tx_ff[0] == tx_ff[1]) || (tx_ff[0] == tx_ff[2])
                        || (tx_ff[1] == tx_ff[2]);
         end
         OP_SETP:     p_ff <= WIDE_W'(opnd);
         OP_MUL_STEP: r_ff <= r_base + addend;
         OP_MUL_DONE: p_ff <= r_ff;
         OP_SUM_SET:  s_ff <= p_ff;
         OP_SUM_SUB:  s_ff <= s_ff - p_ff;
         OP_SUM_ADD:  s_ff <= s_ff + p_ff;
         OP_DEN_SET:  d_ff <= p_ff;
         OP_DIV_INIT: begin
            neg_ff <= s_ff[WIDE_W-1] ^ d_ff[WIDE_W-1];
            nq_ff  <= s_ff[WIDE_W-1] ? WIDE_W'(-s_ff) : WIDE_W'(s_ff);
            dm_ff  <= d_ff[WIDE_W-1] ? WIDE_W'(-d_ff) : WIDE_W'(d_ff);
            rem_ff <= '0;
         end
         OP_DIV_STEP: begin
            if (rem_sh >= {1'b0, dm_ff}) begin
               rem_ff <= rem_sh - {1'b0, dm_ff};
               nq_ff  <= {nq_ff[WIDE_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               nq_ff  <= {nq_ff[WIDE_W-2:0], 1'b0};
            end
         end
         OP_ROUND: nq_ff <= nq_ff + WIDE_W'(up);
         OP_FINISH: begin
            rsp_degen_ff <= degen_ff;
            if (degen_ff) begin
               rsp_value_ff <= '0;
               rsp_sat_ff   <= 1'b0;
            end else if (sat) begin
               rsp_value_ff <= neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
               rsp_sat_ff   <= 1'b1;
            end else begin
               rsp_value_ff <= neg_ff ? (32'd0 - nq_ff[VAL_W-1:0]) : nq_ff[VAL_W-1:0];
               rsp_sat_ff   <= 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_FINISH) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.more     = (hi_ff - lo_ff) > CW'(1);
   assign status.degen    = degen_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_saturated  = rsp_sat_ff;
   assign rsp_degenerate = rsp_degen_ff;

endmodule

[rtl/core/qti_checker.sv]
// Port-level checks for the quadratic table interpolator, bound to the top level.
// Depends on qti_pkg for widths.
module qti_checker import qti_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    req_mode,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [VAL_W-1:0] rsp_value,
   input logic                    rsp_saturated,
   input logic                    rsp_degenerate
);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
      && $stable(rsp_saturated) && $stable(rsp_degenerate))
      else $error("result beat changed while stalled");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_value == 32'sd0 && !rsp_saturated)
      else $error("degenerate result is not zero");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_value == 32'sh7FFF_FFFF
      || rsp_value == 32'sh8000_0000)
      else $error("saturated result is not a range limit");

   // A query beat occupies the block for its whole computation.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == MODE_QUERY) |=> !req_ready)
      else $error("new beat accepted right after a query");

endmodule

bind quadratic_table_interpolator qti_checker u_qti_checker (.*);

[test/tb_quadratic_table_interpolator.sv]
// Testbench for quadratic_table_interpolator: directed table rows, then random table phases.
// Depends on qti_pkg and the RTL top level; results are checked against a built-in predictor.
module tb_quadratic_table_interpolator import qti_pkg::*;;

   localparam int DEPTH       = DEFAULT_DEPTH;
   localparam int ITEM_TARGET = 1250;
   localparam int SETTLE      = 700;
   localparam int STALL_LIMIT = 5000;

   typedef logic signed [159:0] wide_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    saturated;
      logic                    degenerate;
   } interp_result_type;

   typedef struct {
      logic                    mode;
      logic [IDX_W-1:0]        index;
      logic signed [VAL_W-1:0] x;
      logic signed [VAL_W-1:0] y;
      logic signed [VAL_W-1:0] qx;
      logic                    fixed;
      interp_result_type       known;
   } stim_row_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_wr_en;
   logic [LEN_W-1:0]        csr_wr_data;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_mode;
   logic [IDX_W-1:0]        req_entry_index;
   logic signed [VAL_W-1:0] req_entry_x;
   logic signed [VAL_W-1:0] req_entry_y;
   logic signed [VAL_W-1:0] req_query_x;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [VAL_W-1:0] rsp_value;
   logic                    rsp_saturated;
   logic                    rsp_degenerate;

   // Shadow copy of the table and the length register.
   logic signed [VAL_W-1:0] shadow_x [DEPTH];
   logic signed [VAL_W-1:0] shadow_y [DEPTH];
   logic [LEN_W-1:0]        shadow_len;

   interp_result_type pending_results[$];
   stim_row_type      directed_rows[$];
   int                error_count;
   int                items_sent;
   int                idle_cycles;
   logic              quiet;

   quadratic_table_interpolator #(.TABLE_DEPTH(DEPTH)) DUT (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_entry_index(req_entry_index), .req_entry_x(req_entry_x),
      .req_entry_y(req_entry_y), .req_query_x(req_query_x),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_value(rsp_value),
      .rsp_saturated(rsp_saturated), .rsp_degenerate(rsp_degenerate)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic interp_result_type interpolate(input logic signed [VAL_W-1:0] qx);
      int                n, lo, hi, mid, base;
      longint            q, x0, x1, x2, d01, d02, d12;
      wide_type          num, den;
      logic [159:0]      nmag, dmag, quot, rem;
      logic              neg;
      interp_result_type r;
      n = shadow_len;
      if (n < 3) n = 3;
      if (n > DEPTH) n = DEPTH;
      q  = qx;
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (q >= longint'(shadow_x[mid])) lo = mid;
         else hi = mid;
      end
      // Near the top of the table the triple reaches downward instead.
      if (lo < n - 2) base = lo;
      else base = (lo >= 2) ? lo - 2 : 0;
      x0  = shadow_x[base];
      x1  = shadow_x[base + 1];
      x2  = shadow_x[base + 2];
      d01 = x0 - x1;
      d02 = x0 - x2;
      d12 = x1 - x2;
      r = '0;
      r.degenerate = (d01 == 0) || (d02 == 0) || (d12 == 0);
      if (!r.degenerate) begin
         num = wide_type'(shadow_y[base]) * wide_type'(q - x1) * wide_type'(q - x2)
               * wide_type'(d12)
             - wide_type'(shadow_y[base + 1]) * wide_type'(q - x0) * wide_type'(q - x2)
               * wide_type'(d02)
             + wide_type'(shadow_y[base + 2]) * wide_type'(q - x0) * wide_type'(q - x1)
               * wide_type'(d01);
         den  = wide_type'(d01) * wide_type'(d02) * wide_type'(d12);
         neg  = num[159] ^ den[159];
         nmag = num[159] ? -num : num;
         dmag = den[159] ? -den : den;
         quot = nmag / dmag;
         rem  = nmag % dmag;
         if ((rem << 1) >= dmag) quot = quot + 1;
         if (neg ? (quot > 160'h8000_0000) : (quot > 160'h7FFF_FFFF)) begin
            r.saturated = 1'b1;
            r.value     = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            r.value = neg ? -quot[31:0] : quot[31:0];
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // One beat on the request channel; the shadow table and the expected results follow
   // at the edge where the beat is taken.
   task automatic send_beat(input stim_row_type row);
      while (!quiet && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= row.mode;
      req_entry_index <= row.index;
      req_entry_x     <= row.x;
      req_entry_y     <= row.y;
      req_query_x     <= row.qx;
      do @(posedge clock); while (!req_ready);
      if (row.mode == MODE_LOAD) begin
         shadow_x[row.index] = row.x;
         shadow_y[row.index] = row.y;
      end else begin
         pending_results.push_back(row.fixed ? row.known : interpolate(row.qx));
      end
      items_sent++;
      @(negedge clock);
   endtask

   function automatic stim_row_type load_row(input int idx, input logic [31:0] x,
                                             input logic [31:0] y);
      stim_row_type row;
      row = '{mode: MODE_LOAD, index: idx[IDX_W-1:0], x: x, y: y, qx: $urandom,
              fixed: 1'b0, known: '0};
      return row;
   endfunction

   function automatic stim_row_type query_row(input logic [31:0] qx, input logic fixed,
                                              input interp_result_type known);
      stim_row_type row;
      row = '{mode: MODE_QUERY, index: $urandom, x: $urandom, y: $urandom, qx: qx,
              fixed: fixed, known: known};
      return row;
   endfunction

   // The last beat is already taken, so valid drops before anything else happens.
   task automatic wait_idle;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] len);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      shadow_len   = len;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   always @(negedge clock) rsp_ready <= quiet || ($urandom_range(0, 99) >= 11);

   always @(posedge clock) begin
      interp_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_value, 32'h0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_value !== want.value) report_mismatch("value", rsp_value, want.value);
            if (rsp_saturated !== want.saturated)
               report_mismatch("saturated", rsp_saturated, want.saturated);
            if (rsp_degenerate !== want.degenerate)
               report_mismatch("degenerate", rsp_degenerate, want.degenerate);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      interp_result_type  none;
      int                 n, phase, pick, count;
      longint             maxstep, total, start, xcur, span;
      longint             steps [DEPTH];
      logic signed [31:0] qx;
      logic [LEN_W-1:0]   len;
      stim_row_type       row;

      none        = '0;
      error_count = 0;
      items_sent  = 0;
      idle_cycles = 0;
      quiet       = 1'b0;
      shadow_len  = 9'd3;
      for (int k = 0; k < DEPTH; k++) begin
         shadow_x[k] = '0;
         shadow_y[k] = '0;
      end
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_mode = MODE_LOAD;
      req_entry_index = '0;
      req_entry_x = '0;
      req_entry_y = '0;
      req_query_x = '0;
      rsp_ready = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // y = x*x on 0, 1, 2 with the reset length of three.
      directed_rows.push_back(load_row(0, 32'h0, 32'h0));
      directed_rows.push_back(load_row(1, 32'h1_0000, 32'h1_0000));
      directed_rows.push_back(load_row(2, 32'h2_0000, 32'h4_0000));
      directed_rows.push_back(query_row(32'h0, 1'b1, '{32'h0, 1'b0, 1'b0}));
      // Bracket on entry one of a three-entry table still uses the triple from zero.
      directed_rows.push_back(query_row(32'h1_8000, 1'b1, '{32'h2_4000, 1'b0, 1'b0}));
      directed_rows.push_back(query_row(32'h8000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0}));
      directed_rows.push_back(query_row(32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0}));
      directed_rows.push_back(query_row(32'hFFFF_0000, 1'b0, none));
      // y = -x*x clips at the negative end.
      directed_rows.push_back(load_row(1, 32'h1_0000, 32'hFFFF_0000));
      directed_rows.push_back(load_row(2, 32'h2_0000, 32'hFFFC_0000));
      directed_rows.push_back(query_row(32'h8000_0000, 1'b1, '{32'h8000_0000, 1'b1, 1'b0}));
      // Coincident x points.
      directed_rows.push_back(load_row(2, 32'h1_0000, 32'h7FFF_FFFF));
      directed_rows.push_back(query_row(32'h1_0000, 1'b1, '{32'h0, 1'b0, 1'b1}));
      // Extreme abscissas and ordinates.
      directed_rows.push_back(load_row(0, 32'h8000_0000, 32'h7FFF_FFFF));
      directed_rows.push_back(load_row(1, 32'h0, 32'h8000_0000));
      directed_rows.push_back(load_row(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      directed_rows.push_back(query_row(32'h7FFF_FFFF, 1'b0, none));
      directed_rows.push_back(query_row(32'h8000_0000, 1'b0, none));
      directed_rows.push_back(query_row(32'h0000_3039, 1'b0, none));
      // Table in falling order.
      directed_rows.push_back(load_row(0, 32'h5_0000, 32'h0001_2345));
      directed_rows.push_back(load_row(1, 32'h0, 32'hFFF0_0000));
      directed_rows.push_back(load_row(2, 32'hFFFB_0000, 32'h0003_0000));
      directed_rows.push_back(query_row(32'h1_0000, 1'b0, none));
      directed_rows.push_back(query_row(32'hFFFF_8000, 1'b0, none));
      foreach (directed_rows[k]) send_beat(directed_rows[k]);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         pick = $urandom_range(0, 99);
         if (phase == 1) len = 9'd511;
         else if (pick < 4) begin
            case ($urandom_range(0, 2))
               0:       len = 9'd256;
               1:       len = 9'd300;
               default: len = 9'd511;
            endcase
         end else if (pick < 15) len = LEN_W'($urandom_range(0, 3));
         else len = LEN_W'($urandom_range(3, 12));
         write_length(len);
         n = (len < 3) ? 3 : ((len > DEPTH) ? DEPTH : len);

         // A rising table spread over a random share of the whole range, with some random and repeated x points.
         maxstep = 64'h0_FFFF_FFFE / n;
         if ($urandom_range(0, 1)) maxstep = 1 + $urandom_range(1, 4 * 65536);
         total = 0;
         for (int k = 1; k < n; k++) begin
            steps[k] = 1 + ({$urandom, $urandom} % maxstep);
            total    = total + steps[k];
         end
         start = -64'sd2147483648 + ({$urandom, $urandom} % (64'h0_FFFF_FFFF - total + 1));
         xcur  = start;
         for (int k = 0; k < n; k++) begin
            if (k > 0) xcur = xcur + steps[k];
            pick = $urandom_range(0, 99);
            if (pick < 4) row = load_row(k, $urandom, $urandom);
            else if (pick < 8 && k > 0) row = load_row(k, shadow_x[k - 1], $urandom);
            else row = load_row(k, xcur[31:0], $urandom);
            quiet = (items_sent >= 500) && (items_sent < 700);
            send_beat(row);
         end

         count = $urandom_range(8, 20);
         for (int k = 0; k < count; k++) begin
            quiet = (items_sent >= 500) && (items_sent < 700);
            pick  = $urandom_range(0, 99);
            if (pick < 10) begin
               send_beat(load_row($urandom_range(0, n - 1), $urandom, $urandom));
            end else begin
               if (pick < 65) begin
                  span = longint'(shadow_x[n - 1]) - longint'(shadow_x[0]);
                  if (span > 0) qx = shadow_x[0] + ({$urandom, $urandom} % (span + 1));
                  else qx = $urandom;
               end else if (pick < 80) begin
                  qx = shadow_x[$urandom_range(0, n - 1)] + $urandom_range(0, 2) - 1;
               end else begin
                  qx = $urandom;
               end
               send_beat(query_row(qx, 1'b0, none));
            end
         end
         phase++;
      end

      wait_idle();
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
